@@ design/elcsr_pkg.sv @@
package elcsr_pkg;

  localparam int DATA_W = 16;
  localparam int OP_W   = 3;

  // access and event codes
  typedef enum logic [OP_W-1:0] {
    OP_PTR_WR  = 3'd0,
    OP_PTR_RD  = 3'd1,
    OP_CSR_WR  = 3'd2,
    OP_CSR_RD  = 3'd3,
    OP_TX_DONE = 3'd4,
    OP_RX_DONE = 3'd5,
    OP_TICK    = 3'd6
  } op_t;

  // CSR0 bit positions
  localparam int BIT_ERR  = 15;
  localparam int BIT_BABL = 14;
  localparam int BIT_CERR = 13;
  localparam int BIT_MISS = 12;
  localparam int BIT_MERR = 11;
  localparam int BIT_RINT = 10;
  localparam int BIT_TINT = 9;
  localparam int BIT_IDON = 8;
  localparam int BIT_INTR = 7;
  localparam int BIT_INEA = 6;
  localparam int BIT_RXON = 5;
  localparam int BIT_TXON = 4;
  localparam int BIT_TDMD = 3;
  localparam int BIT_STOP = 2;
  localparam int BIT_STRT = 1;
  localparam int BIT_INIT = 0;

  // mode word bits
  localparam int MODE_DTX_BIT = 1;
  localparam int MODE_DRX_BIT = 0;

  localparam logic [DATA_W-1:0] CSR0_RESET     = 16'h0004;
  localparam logic [DATA_W-1:0] ERR_SRC_MASK   = 16'h7800;
  localparam logic [DATA_W-1:0] INTR_SRC_MASK  = 16'h5F00;
  localparam logic [DATA_W-1:0] W1C_MASK       = 16'h7F00;
  localparam logic [DATA_W-1:0] STOP_CLR_MASK  = 16'hFFF8;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
  } result_t;

  // pending INIT, summary bits, MERR and STOP handling
  function automatic logic [DATA_W-1:0] status_fixup(logic [DATA_W-1:0] s_in,
                                                     logic [DATA_W-1:0] mode);
    logic [DATA_W-1:0] s;
    s = s_in;
    if (s[BIT_INIT]) begin
      s[BIT_TXON] = ~mode[MODE_DTX_BIT];
      s[BIT_RXON] = ~mode[MODE_DRX_BIT];
      s[BIT_IDON] = 1'b1;
      s[BIT_INIT] = 1'b0;
    end
    s[BIT_ERR]  = |(s & ERR_SRC_MASK);
    s[BIT_INTR] = |(s & INTR_SRC_MASK);
    if (s[BIT_MERR]) begin
      s[BIT_RXON] = 1'b0;
      s[BIT_TXON] = 1'b0;
    end
    if (s[BIT_STOP]) begin
      s = s & ~STOP_CLR_MASK;
    end
    return s;
  endfunction

  // bus write to CSR0
  function automatic logic [DATA_W-1:0] status_write(logic [DATA_W-1:0] s_in,
                                                     logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] s;
    s = s_in & ~(x & W1C_MASK);
    if (x[BIT_TDMD]) begin
      s[BIT_TDMD] = 1'b1;
    end
    if (x[BIT_STRT]) begin
      s[BIT_STRT] = 1'b1;
      s[BIT_STOP] = 1'b0;
    end
    if (x[BIT_INIT]) begin
      s[BIT_INIT] = 1'b1;
      s[BIT_STOP] = 1'b0;
    end
    if (x[BIT_STOP]) begin
      s[BIT_STOP] = 1'b1;
      s[BIT_STRT] = 1'b0;
      s[BIT_INIT] = 1'b0;
    end
    s[BIT_INEA] = x[BIT_INEA];
    return s;
  endfunction

endpackage

@@ design/ethernet_controller_csr_block_top.sv @@
// Ethernet controller CSR block, CSR0..CSR3 plus register pointer.
// Data path: a request beat is held in the input register, then its result
// in the result register. Throughput: one beat per cycle while out_ready is
// high; the CSR update is one pass of logic between the two registers.
// Reset (rst_n, synchronous, active low): CSR0 = STOP only, CSR1..3, pointer
// and mode word cleared, both channels empty.
module ethernet_controller_csr_block_top
  import elcsr_pkg::*;
#(
  parameter int NUM_CSRS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: mode word of the init block
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  // request beats
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [DATA_W-1:0] in_write_data,
  // result beats
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_irq
);

  logic    item_valid;
  item_t   item;
  logic    can_load;
  logic    fire;
  result_t result;

  // an item leaves the input register when the result register has room;
  // the CSR state commits at that same edge
  assign fire = item_valid & can_load;

  elcsr_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_write_data (in_write_data),
    .advance       (fire),
    .item_valid    (item_valid),
    .item          (item)
  );

  // CSR state, fix-up before and after the access, read mux, irq
  elcsr_regs #(
    .NUM_CSRS (NUM_CSRS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .result      (result)
  );

  // result register; holds a stalled beat while the next item waits upstream
  elcsr_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (fire),
    .result        (result),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_irq       (out_irq)
  );

endmodule

@@ design/elcsr_in_stage.sv @@
module elcsr_in_stage
  import elcsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic              advance,
  output logic              item_valid,
  output item_t             item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready   = ~valid_r | advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.operation  <= in_operation;
      item_r.write_data <= in_write_data;
    end
  end

endmodule

@@ design/elcsr_regs.sv @@
module elcsr_regs
  import elcsr_pkg::*;
#(
  parameter int NUM_CSRS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  logic              fire,
  input  item_t             item,
  output result_t           result
);

  localparam int PTR_W   = $clog2(NUM_CSRS);
  localparam int AUX_N   = NUM_CSRS - 1;
  localparam int AUX_W   = $clog2(AUX_N);

  logic [DATA_W-1:0] mode_r;
  logic [DATA_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] aux_r   [AUX_N];
  logic [DATA_W-1:0] aux_nxt [AUX_N];
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;

  logic [DATA_W-1:0] s_pre;
  logic [DATA_W-1:0] s_mid;
  logic [PTR_W-1:0]  aux_sel;
  logic [AUX_W-1:0]  aux_idx;
  logic [DATA_W-1:0] rd;

  assign aux_sel = ptr_r - PTR_W'(1);
  assign aux_idx = aux_sel[AUX_W-1:0];

  always_comb begin
    s_pre   = status_fixup(status_r, mode_r);
    s_mid   = s_pre;
    aux_nxt = aux_r;
    ptr_nxt = ptr_r;
    rd      = '0;
    case (item.operation)
      OP_PTR_WR: ptr_nxt = item.write_data[PTR_W-1:0];
      OP_PTR_RD: rd = {{(DATA_W-PTR_W){1'b0}}, ptr_r};
      OP_CSR_WR: begin
        if (ptr_r == '0) begin
          s_mid = status_write(s_pre, item.write_data);
        end else begin
          aux_nxt[aux_idx] = item.write_data;
        end
      end
      OP_CSR_RD: rd = (ptr_r == '0) ? s_pre : aux_r[aux_idx];
      OP_TX_DONE: begin
        if (s_pre[BIT_TXON]) begin
          s_mid[BIT_TINT] = 1'b1;
        end
      end
      OP_RX_DONE: begin
        if (s_pre[BIT_RXON]) begin
          s_mid[BIT_RINT] = 1'b1;
        end
      end
      default: ;  // tick and unused code: fix-up only
    endcase
    status_nxt       = status_fixup(s_mid, mode_r);
    result.read_data = rd;
    result.irq       = status_nxt[BIT_INTR] & status_nxt[BIT_INEA];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      status_r <= CSR0_RESET;
      ptr_r    <= '0;
      for (int i = 0; i < AUX_N; i++) begin
        aux_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (fire) begin
        status_r <= status_nxt;
        ptr_r    <= ptr_nxt;
        aux_r    <= aux_nxt;
      end
    end
  end

endmodule

@@ design/elcsr_out_stage.sv @@
module elcsr_out_stage
  import elcsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  result_t           result,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_irq
);

  logic    valid_r;
  result_t result_r;

  assign can_load      = ~valid_r | out_ready;
  assign out_valid     = valid_r;
  assign out_read_data = result_r.read_data;
  assign out_irq       = result_r.irq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

@@ tb/csr_shadow_pkg.sv @@
`timescale 1ns / 1ps
package csr_shadow_pkg;
  import elcsr_pkg::*;

  // unused operation code; the block treats it as a tick
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  // Shadow copy of CSR0..CSR3, pointer and mode word, plus the replies it predicts.
  class csr_shadow;
    logic [DATA_W-1:0] csr0;
    logic [DATA_W-1:0] aux [3];
    logic [1:0]        ptr;
    logic [DATA_W-1:0] mode;
    result_t           expected_replies [$];
    int                mismatches;
    int                replies_seen;

    function new();
      csr0 = CSR0_RESET;
      foreach (aux[i]) aux[i] = '0;
      ptr          = '0;
      mode         = '0;
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    function void set_mode(logic [DATA_W-1:0] value);
      mode = value;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // pending INIT, summary bits, MERR kill, STOP clear
    function logic [DATA_W-1:0] settle_status(logic [DATA_W-1:0] s);
      if (s[BIT_INIT]) begin
        s[BIT_TXON] = !mode[MODE_DTX_BIT];
        s[BIT_RXON] = !mode[MODE_DRX_BIT];
        s[BIT_IDON] = 1'b1;
        s[BIT_INIT] = 1'b0;
      end
      s[BIT_ERR]  = s[BIT_BABL] | s[BIT_CERR] | s[BIT_MISS] | s[BIT_MERR];
      s[BIT_INTR] = s[BIT_BABL] | s[BIT_MISS] | s[BIT_MERR] |
                    s[BIT_RINT] | s[BIT_TINT] | s[BIT_IDON];
      if (s[BIT_MERR]) begin
        s[BIT_RXON] = 1'b0;
        s[BIT_TXON] = 1'b0;
      end
      if (s[BIT_STOP]) s[DATA_W-1:BIT_TDMD] = '0;
      return s;
    endfunction

    function logic [DATA_W-1:0] apply_csr0_write(logic [DATA_W-1:0] s,
                                                 logic [DATA_W-1:0] x);
      for (int b = BIT_IDON; b <= BIT_BABL; b++) begin
        if (x[b]) s[b] = 1'b0;
      end
      if (x[BIT_TDMD]) s[BIT_TDMD] = 1'b1;
      if (x[BIT_STRT]) begin
        s[BIT_STRT] = 1'b1;
        s[BIT_STOP] = 1'b0;
      end
      if (x[BIT_INIT]) begin
        s[BIT_INIT] = 1'b1;
        s[BIT_STOP] = 1'b0;
      end
      if (x[BIT_STOP]) begin
        s[BIT_STOP] = 1'b1;
        s[BIT_STRT] = 1'b0;
        s[BIT_INIT] = 1'b0;
      end
      s[BIT_INEA] = x[BIT_INEA];
      return s;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] wd);
      result_t           r;
      logic [DATA_W-1:0] rd;
      rd   = '0;
      csr0 = settle_status(csr0);
      case (op)
        OP_PTR_WR: ptr = wd[1:0];
        OP_PTR_RD: rd = {{(DATA_W-2){1'b0}}, ptr};
        OP_CSR_WR: begin
          if (ptr == 2'd0) csr0 = apply_csr0_write(csr0, wd);
          else aux[ptr - 2'd1] = wd;
        end
        OP_CSR_RD: rd = (ptr == 2'd0) ? csr0 : aux[ptr - 2'd1];
        OP_TX_DONE: if (csr0[BIT_TXON]) csr0[BIT_TINT] = 1'b1;
        OP_RX_DONE: if (csr0[BIT_RXON]) csr0[BIT_RINT] = 1'b1;
        default: ;
      endcase
      csr0        = settle_status(csr0);
      r.read_data = rd;
      r.irq       = csr0[BIT_INTR] & csr0[BIT_INEA];
      expected_replies.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH %s", msg);
    endtask

    task check_reply(logic [DATA_W-1:0] rd, logic irq);
      result_t want;
      replies_seen++;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply %0d arrived with none outstanding", replies_seen));
        return;
      end
      want = expected_replies.pop_front();
      if (rd !== want.read_data)
        report($sformatf("reply %0d read_data got %h want %h",
                         replies_seen, rd, want.read_data));
      if (irq !== want.irq)
        report($sformatf("reply %0d irq got %b want %b", replies_seen, irq, want.irq));
    endtask
  endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import elcsr_pkg::*;
  import csr_shadow_pkg::*;

  localparam int ITEMS_PER_PHASE = 255;

  // single-bit CSR0 words for the directed beats
  localparam logic [DATA_W-1:0] W_INIT = DATA_W'(1) << BIT_INIT;
  localparam logic [DATA_W-1:0] W_STRT = DATA_W'(1) << BIT_STRT;
  localparam logic [DATA_W-1:0] W_TDMD = DATA_W'(1) << BIT_TDMD;
  localparam logic [DATA_W-1:0] W_INEA = DATA_W'(1) << BIT_INEA;
  localparam logic [DATA_W-1:0] W_IDON = DATA_W'(1) << BIT_IDON;
  localparam logic [DATA_W-1:0] W_TINT = DATA_W'(1) << BIT_TINT;
  localparam logic [DATA_W-1:0] W_RINT = DATA_W'(1) << BIT_RINT;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [DATA_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [DATA_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_read_data;
  logic              out_irq;

  csr_shadow shadow = new();

  // remaining beats in a no-idle stretch, per side
  int send_quiet;
  int recv_quiet;

  ethernet_controller_csr_block_top #(
    .NUM_CSRS(4)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_irq      (out_irq)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (all gaps and stalls maxed).
  initial begin
    #5_000_000;
    $display("ethernet_controller_csr_block_top regression: fail");
    $finish;
  end

  // Monitor: every accepted request beat feeds the shadow, which predicts its
  // reply; every accepted reply beat is checked against the oldest prediction.
  // Requests are noted first so a reply in the same cycle would still line up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) shadow.note_request(in_operation, in_write_data);
      if (out_valid && out_ready) shadow.check_reply(out_read_data, out_irq);
    end
  end

  // Reply sink: draws a random stall before each reply beat, with
  // occasional stretches of back-to-back acceptance.
  initial begin : reply_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (recv_quiet > 0) begin
        stall = 0;
        recv_quiet--;
      end else begin
        stall = $urandom_range(0, 10);
        if ($urandom_range(0, 29) == 0) recv_quiet = $urandom_range(15, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One request beat: optional idle gap, then hold valid until accepted.
  // Returns at the accepting edge with valid still high, so the next beat can
  // follow with no bubble.
  task automatic send_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] wd);
    int gap;
    if (send_quiet > 0) begin
      gap = 0;
      send_quiet--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 29) == 0) send_quiet = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_write_data <= wd;
    do @(posedge clk); while (!in_ready);
  endtask

  // Park the sender until every predicted reply is back. The first edge lets
  // the monitor note the last accepted beat before the queue is looked at.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Mode word write; only called with the block idle.
  task automatic write_mode(logic [DATA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.set_mode(value);
  endtask

  // Random beat, biased toward driver-like traffic: the pointer mostly goes
  // back to CSR0, CSR0 writes rarely carry STOP so the engines stay up long
  // enough for frame-done events to land. About one CSR write in five is raw noise.
  task automatic random_beat();
    int                pick;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] wd;
    pick = $urandom_range(0, 99);
    wd   = DATA_W'($urandom);
    if (pick < 10) begin
      op = OP_PTR_WR;
      if ($urandom_range(0, 4) < 3) wd[1:0] = 2'd0;
    end else if (pick < 18) begin
      op = OP_PTR_RD;
    end else if (pick < 43) begin
      op = OP_CSR_WR;
      if ($urandom_range(0, 9) != 0 && $urandom_range(0, 7) != 0) wd[BIT_STOP] = 1'b0;
    end else if (pick < 58) begin
      op = OP_CSR_RD;
    end else if (pick < 73) begin
      op = OP_TX_DONE;
    end else if (pick < 88) begin
      op = OP_RX_DONE;
    end else if (pick < 96) begin
      op = OP_TICK;
    end else begin
      op = OP_SPARE;
    end
    send_beat(op, wd);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] mode_plan [7];
    mode_plan = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'hFFFC, 16'h0000, 16'h0003};
    mode_plan[5] = DATA_W'($urandom);

    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_operation  <= OP_TICK;
    in_write_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset value, events while stopped, INIT bring-up, frame done,
    // write-one-to-clear, STRT/TDMD, spare opcode, INIT while running, STOP
    // winning over STRT and INIT, pointer wrap, CSR1..3 access while stopped.
    write_mode(16'h0000);
    send_beat(OP_CSR_RD,  16'h0000);
    send_beat(OP_TX_DONE, 16'hFFFF);
    send_beat(OP_RX_DONE, 16'h0000);
    send_beat(OP_CSR_WR,  16'h0000);
    send_beat(OP_CSR_WR,  W_INIT | W_INEA);
    send_beat(OP_CSR_RD,  16'h0000);
    send_beat(OP_TX_DONE, 16'h0000);
    send_beat(OP_RX_DONE, 16'h0000);
    send_beat(OP_CSR_RD,  16'h0000);
    send_beat(OP_CSR_WR,  W_TINT | W_RINT | W_IDON | W_INEA);
    send_beat(OP_CSR_WR,  W_TDMD | W_STRT | W_INEA);
    send_beat(OP_SPARE,   16'hFFFF);
    send_beat(OP_TICK,    16'h0000);
    send_beat(OP_CSR_WR,  W_INIT | W_INEA);
    send_beat(OP_CSR_WR,  16'hFFFF);
    send_beat(OP_CSR_RD,  16'h0000);
    send_beat(OP_PTR_WR,  16'hFFFF);
    send_beat(OP_PTR_RD,  16'h0000);
    send_beat(OP_CSR_WR,  16'hFFFF);
    send_beat(OP_CSR_RD,  16'h0000);
    send_beat(OP_PTR_WR,  16'h0002);
    send_beat(OP_CSR_RD,  16'h0000);
    send_beat(OP_PTR_WR,  16'hFFFC);
    send_beat(OP_CSR_WR,  W_STRT);
    send_beat(OP_CSR_RD,  16'h0000);
    wait_drained();

    // Random phases, one per mode word; each boundary drains the block fully
    // before the mode register is touched.
    foreach (mode_plan[p]) begin
      write_mode(mode_plan[p]);
      repeat (ITEMS_PER_PHASE) random_beat();
      wait_drained();
    end

    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("ethernet_controller_csr_block_top regression: pass");
    else
      $display("ethernet_controller_csr_block_top regression: fail");
    $finish;
  end

endmodule
